// ===== hw/rtl/aip_pkg.sv =====
// shared constants and character-class helpers for the ascii integer parser
`timescale 1ns / 1ps

package aip_pkg;

    // widths of the payload fields
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned NUM_W  = 32;
    localparam int unsigned NIB_W  = 4;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

    // reset value of the signed_mode register
    localparam logic SIGNED_MODE_RST = 1'b1;

    // hex digit value plus a flag that says it is a hex digit
    typedef struct packed {
        logic             ok;
        logic [NIB_W-1:0] val;
    } t_hex_dig;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_dec(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic t_hex_dig hex_digit(input logic [CHAR_W-1:0] c);
        t_hex_dig   d;
        logic [CHAR_W-1:0] diff;
        d    = '0;
        diff = '0;
        if (is_dec(c)) begin
            diff  = c - CH_ZERO;
            d.ok  = 1'b1;
            d.val = diff[NIB_W-1:0];
        end else if ((c >= CH_LO_A) && (c <= CH_LO_F)) begin
            diff  = c - CH_LO_A + 8'd10;
            d.ok  = 1'b1;
            d.val = diff[NIB_W-1:0];
        end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
            diff  = c - CH_UP_A + 8'd10;
            d.ok  = 1'b1;
            d.val = diff[NIB_W-1:0];
        end
        return d;
    endfunction

endpackage

// ===== hw/rtl/ascii_integer_parser.sv =====
// A terminator byte is captured in the input register, and its result is then
// registered in the result register, from which it can be taken.
// Throughput: one text byte per cycle unless the input stalls; the parse state
// updates through a shift-and-add multiply by ten or a shift for sixteen.
// Input stalls only while a held terminator meets a result waiting on a stalled output.
// Reset (synchronous, active low) clears both stages, the parse state and
// sets signed_mode to one.
`timescale 1ns / 1ps

module ascii_integer_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data,
    // text input
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [aip_pkg::CHAR_W-1:0]  i_text_byte,
    // result output
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [aip_pkg::NUM_W-1:0]   o_number,
    output logic                        o_parse_error
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_AFTER_SIGN,
        PH_ZERO,
        PH_DEC,
        PH_HEX,
        PH_TRAIL,
        PH_ERROR
    } t_phase;

    logic                        r_signed_mode;
    logic                        r_in_valid;
    logic [aip_pkg::CHAR_W-1:0]  r_in_byte;
    t_phase                      r_phase, n_phase;
    logic [aip_pkg::NUM_W-1:0]   r_acc, n_acc;
    logic                        r_neg, n_neg;
    logic                        r_out_valid;
    logic [aip_pkg::NUM_W-1:0]   r_out_number;
    logic                        r_out_error;

    logic                        is_term;
    logic                        adv;
    logic [aip_pkg::CHAR_W-1:0]  dec_diff;
    logic [aip_pkg::NIB_W-1:0]   dec_val;
    aip_pkg::t_hex_dig           hex_d;
    logic [aip_pkg::NUM_W-1:0]   acc_x10;
    logic [aip_pkg::NUM_W-1:0]   acc_x16;
    logic                        res_ok;
    logic [aip_pkg::NUM_W-1:0]   res_val;

    // stage control: the held byte moves on unless it is a terminator blocked at the output
    assign is_term = (r_in_byte == aip_pkg::CH_NUL);
    assign adv     = r_in_valid && (!is_term || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !adv;

    // digit decode and scaled accumulator
    assign dec_diff = r_in_byte - aip_pkg::CH_ZERO;
    assign dec_val  = dec_diff[aip_pkg::NIB_W-1:0];
    assign hex_d    = aip_pkg::hex_digit(r_in_byte);
    assign acc_x10  = (r_acc << 3) + (r_acc << 1)
                    + {{(aip_pkg::NUM_W-aip_pkg::NIB_W){1'b0}}, dec_val};
    assign acc_x16  = {r_acc[aip_pkg::NUM_W-aip_pkg::NIB_W-1:0], hex_d.val};

    // result of a terminator
    assign res_ok  = (r_phase == PH_ZERO) || (r_phase == PH_DEC)
                  || (r_phase == PH_HEX)  || (r_phase == PH_TRAIL);
    assign res_val = r_neg ? ('0 - r_acc) : r_acc;

    // next parse state for the held byte
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_neg   = r_neg;
        if (is_term) begin
            n_phase = PH_LEAD;
            n_acc   = '0;
            n_neg   = 1'b0;
        end else begin
            unique case (r_phase)
                PH_LEAD, PH_AFTER_SIGN: begin
                    if (aip_pkg::is_ws(r_in_byte)) begin
                        n_phase = r_phase;
                    end else if ((r_phase == PH_LEAD) && r_signed_mode
                                 && ((r_in_byte == aip_pkg::CH_MINUS)
                                     || (r_in_byte == aip_pkg::CH_PLUS))) begin
                        n_neg   = (r_in_byte == aip_pkg::CH_MINUS);
                        n_phase = PH_AFTER_SIGN;
                    end else if (r_in_byte == aip_pkg::CH_ZERO) begin
                        n_acc   = '0;
                        n_phase = PH_ZERO;
                    end else if (aip_pkg::is_dec(r_in_byte)) begin
                        n_acc   = {{(aip_pkg::NUM_W-aip_pkg::NIB_W){1'b0}}, dec_val};
                        n_phase = PH_DEC;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_ZERO: begin
                    if (r_in_byte == aip_pkg::CH_LO_X) begin
                        n_acc   = '0;
                        n_phase = PH_HEX;
                    end else if (aip_pkg::is_dec(r_in_byte)) begin
                        n_acc   = acc_x10;
                        n_phase = PH_DEC;
                    end else if (aip_pkg::is_ws(r_in_byte)) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_DEC: begin
                    if (aip_pkg::is_dec(r_in_byte)) begin
                        n_acc = acc_x10;
                    end else if (aip_pkg::is_ws(r_in_byte)) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_HEX: begin
                    if (hex_d.ok) begin
                        n_acc = acc_x16;
                    end else if (aip_pkg::is_ws(r_in_byte)) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_TRAIL: begin
                    if (!aip_pkg::is_ws(r_in_byte)) begin
                        n_phase = PH_ERROR;
                    end
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= aip_pkg::SIGNED_MODE_RST;
        end else if (i_cfg_wr_en) begin
            r_signed_mode <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_text_byte;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_acc   <= '0;
            r_neg   <= 1'b0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && is_term) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && is_term) begin
            r_out_number <= res_ok ? res_val : '0;
            r_out_error  <= !res_ok;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_number      = r_out_number;
    assign o_parse_error = r_out_error;

endmodule

// ===== hw/rtl/aip_checker.sv =====
// port-level checks for the ascii integer parser and their bind
`timescale 1ns / 1ps

module aip_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_stall,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [aip_pkg::NUM_W-1:0]   o_number,
    input  logic                        o_parse_error
);

    // an error beat always carries a zero number
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_parse_error) |-> (o_number == '0))
        else $error("error beat with nonzero number");

    // input is held back only while a result sits on a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // a blocked result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_number) && $stable(o_parse_error)))
        else $error("stalled result beat changed");

    // with the output free the input never stalls in that same cycle
    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while output is free");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_number      (o_number),
    .o_parse_error (o_parse_error)
);
